/* src/ccpd_pkg.sv */
// Shared types, sizes, result codes and the CRC byte step for the COBS/CRC deframer.
// Depends on nothing; imported by the deframer top level.
`default_nettype none
package ccpd_pkg;

   localparam int FRAME_CAPACITY   = 512;
   localparam int DECODED_CAPACITY = 512;
   localparam int MAX_PAYLOAD      = 256;

   localparam int FRM_AW = $clog2(FRAME_CAPACITY);
   localparam int FRM_CW = $clog2(FRAME_CAPACITY + 1);
   localparam int DEC_AW = $clog2(DECODED_CAPACITY);
   localparam int DEC_CW = $clog2(DECODED_CAPACITY + 1);
   localparam int PLEN_W = 9;
   // wide enough for any count, run or 16-bit length sum
   localparam int CMP_W  = 18;

   localparam int HDR_LEN = 9;
   localparam int CRC_LEN = 2;
   localparam int HDR_IW  = $clog2(HDR_LEN);

   localparam logic [1:0] KIND_GOOD = 2'd0;
   localparam logic [1:0] KIND_ERR  = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_OVERFLOW    = 3'd1;
   localparam logic [2:0] ST_MALFORMED   = 3'd2;
   localparam logic [2:0] ST_TOO_SMALL   = 3'd3;
   localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;
   localparam logic [2:0] ST_BAD_MAGIC   = 3'd5;
   localparam logic [2:0] ST_BAD_VERSION = 3'd6;
   localparam logic [2:0] ST_BAD_CRC     = 3'd7;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] CSR_MAGIC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_MAGIC_SECOND = 2'd1;
   localparam logic [1:0] CSR_VERSION      = 2'd2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic       cmd;
      logic [7:0] byte_value;
      logic [7:0] payload_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        status;
      logic [7:0]        message_type;
      logic [7:0]        message_flags;
      logic [15:0]       sequence_number;
      logic [PLEN_W-1:0] payload_length;
      logic [7:0]        read_byte;
   } rsp_type;

   // one data byte through CRC-16/CCITT-FALSE, MSB first
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* src/ccpd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none
module ccpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/cobs_crc_packet_deframer_unit.sv */
// COBS deframer with CRC-16/CCITT-FALSE packet check, top level.
// Depends on ccpd_pkg and ccpd_ram (frame store and decoded store).
//
// Pushed data bytes are written into the frame store without stalling, but for
// the byte that overflows the store, which holds the request side for its error. A
// zero delimiter starts a walk of the stored frame: each code byte and each data
// byte is read from the frame store and the data written to the decoded store,
// then a pass over header and payload through the decoded store's read port
// forms the CRC. A read request inside the stored payload passes a wait state
// for the decoded-store read; one outside it goes straight to its result.
// Results wait in an output register; one request is worked on at a time and
// req_stall is high until its result is queued.
`default_nettype none
module cobs_crc_packet_deframer_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ccpd_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ccpd_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_data
);
   import ccpd_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CODE_RD = 4'd1;
   localparam logic [3:0] S_CODE    = 4'd2;
   localparam logic [3:0] S_COPY_RD = 4'd3;
   localparam logic [3:0] S_COPY    = 4'd4;
   localparam logic [3:0] S_CRC_RD  = 4'd5;
   localparam logic [3:0] S_CRC     = 4'd6;
   localparam logic [3:0] S_RD_WAIT = 4'd7;
   localparam logic [3:0] S_FINISH  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [7:0]        magic1_ff, magic2_ff, version_ff;
   logic [FRM_CW-1:0] count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [PLEN_W-1:0] spl_ff, spl_in;
   logic [FRM_CW-1:0] n_ff, n_in, r_ff, r_in;
   logic [DEC_CW-1:0] w_ff, w_in, i_ff, i_in, body_ff, body_in;
   logic [7:0]        code_ff, code_in, run_ff, run_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        hdr_ff [HDR_LEN];
   logic [7:0]        prev_ff, last_ff;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic              frm_we;
   logic [7:0]        frm_rdata;
   logic              dec_we;
   logic [7:0]        dec_wdata, dec_rdata;
   logic [DEC_AW-1:0] dec_raddr;

   logic              accept, out_free;
   logic [CMP_W-1:0]  pos, plen, len;

   ccpd_ram #(.WIDTH(8), .DEPTH(FRAME_CAPACITY)) u_frame (
      .clock  (clock),
      .wr_en  (frm_we),
      .wr_addr(count_ff[FRM_AW-1:0]),
      .wr_data(req_payload.byte_value),
      .rd_addr(r_ff[FRM_AW-1:0]),
      .rd_data(frm_rdata)
   );

   ccpd_ram #(.WIDTH(8), .DEPTH(DECODED_CAPACITY)) u_decoded (
      .clock  (clock),
      .wr_en  (dec_we),
      .wr_addr(w_ff[DEC_AW-1:0]),
      .wr_data(dec_wdata),
      .rd_addr(dec_raddr),
      .rd_data(dec_rdata)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   assign pos  = CMP_W'(HDR_LEN) + CMP_W'(req_payload.payload_index);
   assign plen = CMP_W'({hdr_ff[8], hdr_ff[7]});
   assign len  = CMP_W'(w_ff);
   assign dec_raddr = (state_ff == S_IDLE) ? pos[DEC_AW-1:0] : i_ff[DEC_AW-1:0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      spl_in    = spl_ff;
      n_in      = n_ff;
      r_in      = r_ff;
      w_in      = w_ff;
      i_in      = i_ff;
      body_in   = body_ff;
      code_in   = code_ff;
      run_in    = run_ff;
      crc_in    = crc_ff;
      res_in    = res_ff;
      frm_we    = 1'b0;
      dec_we    = 1'b0;
      dec_wdata = frm_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in = '0;
               if (req_payload.cmd == CMD_READ) begin
                  res_in.kind = KIND_READ;
                  if (CMP_W'(req_payload.payload_index) < CMP_W'(spl_ff) &&
                      pos < CMP_W'(DECODED_CAPACITY)) begin
                     state_in = S_RD_WAIT;
                  end else begin
                     state_in = S_FINISH;
                  end
               end else if (req_payload.byte_value != 8'd0) begin
                  if (!ovf_ff) begin
                     if (count_ff >= FRM_CW'(FRAME_CAPACITY)) begin
                        ovf_in        = 1'b1;
                        res_in.kind   = KIND_ERR;
                        res_in.status = ST_OVERFLOW;
                        state_in      = S_FINISH;
                     end else begin
                        frm_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
               end else if (ovf_ff) begin
                  count_in      = '0;
                  ovf_in        = 1'b0;
                  res_in.kind   = KIND_ERR;
                  res_in.status = ST_OVERFLOW;
                  state_in      = S_FINISH;
               end else if (count_ff != '0) begin
                  n_in     = count_ff;
                  count_in = '0;
                  r_in     = '0;
                  w_in     = '0;
                  res_in.kind = KIND_ERR;
                  state_in = S_CODE_RD;
               end
            end
         end
         S_CODE_RD: begin
            if (r_ff < n_ff) begin
               state_in = S_CODE;
            end else if (w_ff < DEC_CW'(HDR_LEN + CRC_LEN)) begin
               res_in.status = ST_BAD_LENGTH;
               state_in      = S_FINISH;
            end else if (hdr_ff[0] != magic1_ff || hdr_ff[1] != magic2_ff) begin
               res_in.status = ST_BAD_MAGIC;
               state_in      = S_FINISH;
            end else if (hdr_ff[2] != version_ff) begin
               res_in.status = ST_BAD_VERSION;
               state_in      = S_FINISH;
            end else if (plen > CMP_W'(MAX_PAYLOAD) ||
                         len != plen + CMP_W'(HDR_LEN + CRC_LEN)) begin
               res_in.status = ST_BAD_LENGTH;
               state_in      = S_FINISH;
            end else begin
               body_in  = DEC_CW'(plen + CMP_W'(HDR_LEN));
               i_in     = '0;
               crc_in   = CRC_INIT;
               state_in = S_CRC_RD;
            end
         end
         S_CODE: begin
            if (frm_rdata == 8'd0 ||
                CMP_W'(frm_rdata - 8'd1) > CMP_W'(n_ff) - CMP_W'(r_ff) - CMP_W'(1)) begin
               res_in.status = ST_MALFORMED;
               state_in      = S_FINISH;
            end else if (CMP_W'(frm_rdata - 8'd1) >
                         CMP_W'(DECODED_CAPACITY) - CMP_W'(w_ff)) begin
               res_in.status = ST_TOO_SMALL;
               state_in      = S_FINISH;
            end else begin
               code_in  = frm_rdata;
               run_in   = frm_rdata - 8'd1;
               r_in     = r_ff + 1'b1;
               state_in = S_COPY_RD;
            end
         end
         S_COPY_RD: begin
            if (run_ff != 8'd0) begin
               state_in = S_COPY;
            end else if (code_ff != 8'hFF && r_ff < n_ff) begin
               if (w_ff >= DEC_CW'(DECODED_CAPACITY)) begin
                  res_in.status = ST_TOO_SMALL;
                  state_in      = S_FINISH;
               end else begin
                  dec_we    = 1'b1;
                  dec_wdata = 8'd0;
                  w_in      = w_ff + 1'b1;
                  state_in  = S_CODE_RD;
               end
            end else begin
               state_in = S_CODE_RD;
            end
         end
         S_COPY: begin
            dec_we   = 1'b1;
            w_in     = w_ff + 1'b1;
            r_in     = r_ff + 1'b1;
            run_in   = run_ff - 8'd1;
            state_in = S_COPY_RD;
         end
         S_CRC_RD: begin
            if (i_ff < body_ff) begin
               state_in = S_CRC;
            end else if (crc_ff != {last_ff, prev_ff}) begin
               res_in.status = ST_BAD_CRC;
               state_in      = S_FINISH;
            end else begin
               spl_in                 = plen[PLEN_W-1:0];
               res_in.kind            = KIND_GOOD;
               res_in.status          = ST_OK;
               res_in.message_type    = hdr_ff[3];
               res_in.message_flags   = hdr_ff[4];
               res_in.sequence_number = {hdr_ff[6], hdr_ff[5]};
               res_in.payload_length  = plen[PLEN_W-1:0];
               state_in               = S_FINISH;
            end
         end
         S_CRC: begin
            crc_in   = crc_step(crc_ff, dec_rdata);
            i_in     = i_ff + 1'b1;
            state_in = S_CRC_RD;
         end
         S_RD_WAIT: begin
            res_in.read_byte = dec_rdata;
            state_in         = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         magic1_ff    <= '0;
         magic2_ff    <= '0;
         version_ff   <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         spl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         spl_ff   <= spl_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MAGIC_FIRST:  magic1_ff  <= csr_data;
               CSR_MAGIC_SECOND: magic2_ff  <= csr_data;
               CSR_VERSION:      version_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_FINISH && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      r_ff    <= r_in;
      w_ff    <= w_in;
      i_ff    <= i_in;
      body_ff <= body_in;
      code_ff <= code_in;
      run_ff  <= run_in;
      crc_ff  <= crc_in;
      res_ff  <= res_in;
      if (state_ff == S_FINISH && out_free) rsp_ff <= res_ff;
      // keep header bytes and the last two decoded bytes for the checks
      if (dec_we) begin
         if (w_ff < DEC_CW'(HDR_LEN)) hdr_ff[w_ff[HDR_IW-1:0]] <= dec_wdata;
         prev_ff <= last_ff;
         last_ff <= dec_wdata;
      end
   end
endmodule
`default_nettype wire

/* tb/tb_cobs_crc_packet_deframer_unit.sv */
// Self-checking testbench for the COBS/CRC packet deframer top level.
// Depends on ccpd_pkg for the request/response types and codes, and on the deframer RTL.
// Pushes directed rows, then encoded packets, faults, noise and reads; results checked in order.
`default_nettype none
module tb_cobs_crc_packet_deframer_unit;
   import ccpd_pkg::*;

   localparam int SETTLE_CYCLES = 1500;
   localparam int ITEM_TARGET   = 1250;
   localparam int QUIET_FROM    = 1100;

   typedef enum int {
      PKT_GOOD, PKT_BAD_MAGIC, PKT_BAD_VERSION, PKT_BAD_CRC, PKT_BAD_LEN_FIELD,
      PKT_TRUNCATED, PKT_CORRUPT_CODE, PKT_HUGE_LEN
   } pkt_fault_type;

   typedef struct {
      req_type req;
      bit      typed;
      bit      t_has;
      rsp_type t_rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0] csr_index = CSR_MAGIC_FIRST;
   logic [7:0] csr_data = 8'h00;

   // predictor state
   logic [7:0] frame_mem [0:FRAME_CAPACITY-1];
   logic [7:0] dec_mem [0:DECODED_CAPACITY-1];
   int         frame_fill;
   bit         frame_ovf;
   int         good_plen;
   logic [7:0] cfg_magic1, cfg_magic2, cfg_version;

   rsp_type expected_results[$];
   int      error_count = 0;
   int      requests_sent = 0;
   int      results_seen = 0;
   int      good_seen = 0;
   int      err_seen = 0;
   bit      quiet = 1'b0;
   bit      long_hold = 1'b0;
   int      stall_left = 0;

   cobs_crc_packet_deframer_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 4_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      c = crc ^ {d, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [2:0] cobs_unstuff(output int len);
      int rd, wr, code, run;
      rd = 0;
      wr = 0;
      len = 0;
      while (rd < frame_fill) begin
         code = frame_mem[rd];
         rd++;
         if (code == 0) return ST_MALFORMED;
         run = code - 1;
         if (run > frame_fill - rd) return ST_MALFORMED;
         if (run > DECODED_CAPACITY - wr) return ST_TOO_SMALL;
         for (int k = 0; k < run; k++) begin
            dec_mem[wr] = frame_mem[rd];
            wr++;
            rd++;
         end
         if (code != 255 && rd < frame_fill) begin
            if (wr >= DECODED_CAPACITY) return ST_TOO_SMALL;
            dec_mem[wr] = 8'h00;
            wr++;
         end
      end
      len = wr;
      return ST_OK;
   endfunction

   function automatic logic [2:0] packet_status(input int len);
      int plen, body;
      logic [15:0] crc;
      if (len < HDR_LEN + CRC_LEN) return ST_BAD_LENGTH;
      if (dec_mem[0] != cfg_magic1 || dec_mem[1] != cfg_magic2) return ST_BAD_MAGIC;
      if (dec_mem[2] != cfg_version) return ST_BAD_VERSION;
      plen = {dec_mem[8], dec_mem[7]};
      if (plen > MAX_PAYLOAD || len != HDR_LEN + plen + CRC_LEN) return ST_BAD_LENGTH;
      body = HDR_LEN + plen;
      crc = CRC_INIT;
      for (int i = 0; i < body; i++) crc = crc16_update(crc, dec_mem[i]);
      if (crc != {dec_mem[body+1], dec_mem[body]}) return ST_BAD_CRC;
      return ST_OK;
   endfunction

   function automatic bit deframe_predict(input req_type r, output rsp_type o);
      logic [2:0] st;
      int len;
      o = '0;
      if (r.cmd == CMD_READ) begin
         o.kind = KIND_READ;
         if (r.payload_index < good_plen) o.read_byte = dec_mem[HDR_LEN + r.payload_index];
         return 1'b1;
      end
      if (r.byte_value != 8'h00) begin
         if (frame_ovf) return 1'b0;
         if (frame_fill >= FRAME_CAPACITY) begin
            frame_ovf = 1'b1;
            o.kind = KIND_ERR;
            o.status = ST_OVERFLOW;
            return 1'b1;
         end
         frame_mem[frame_fill] = r.byte_value;
         frame_fill++;
         return 1'b0;
      end
      if (frame_ovf) begin
         frame_fill = 0;
         frame_ovf = 1'b0;
         o.kind = KIND_ERR;
         o.status = ST_OVERFLOW;
         return 1'b1;
      end
      if (frame_fill == 0) return 1'b0;
      st = cobs_unstuff(len);
      frame_fill = 0;
      if (st == ST_OK) st = packet_status(len);
      if (st != ST_OK) begin
         o.kind = KIND_ERR;
         o.status = st;
         return 1'b1;
      end
      good_plen = len - HDR_LEN - CRC_LEN;
      o.kind = KIND_GOOD;
      o.message_type = dec_mem[3];
      o.message_flags = dec_mem[4];
      o.sequence_number = {dec_mem[6], dec_mem[5]};
      o.payload_length = good_plen[PLEN_W-1:0];
      return 1'b1;
   endfunction

   function automatic rsp_type err_rsp(input logic [2:0] st);
      rsp_type o;
      o = '0;
      o.kind = KIND_ERR;
      o.status = st;
      return o;
   endfunction

   function automatic rsp_type read_rsp(input logic [7:0] b);
      rsp_type o;
      o = '0;
      o.kind = KIND_READ;
      o.read_byte = b;
      return o;
   endfunction

   function automatic req_type push_req(input logic [7:0] b);
      req_type r;
      r.cmd = CMD_PUSH;
      r.byte_value = b;
      r.payload_index = 8'($urandom);
      return r;
   endfunction

   function automatic req_type read_req(input logic [7:0] idx);
      req_type r;
      r.cmd = CMD_READ;
      r.byte_value = 8'($urandom);
      r.payload_index = idx;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
   endtask

   // hold the request until accepted, then advance the predictor
   task automatic send_request(input req_type r, input bit typed = 1'b0,
                               input bit t_has = 1'b0, input rsp_type t_rsp = '0);
      rsp_type p;
      bit has;
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      has = deframe_predict(r, p);
      if (typed) begin
         has = t_has;
         p = t_rsp;
      end
      if (has) expected_results.push_back(p);
      requests_sent++;
      if (requests_sent >= QUIET_FROM) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAGIC_FIRST:  cfg_magic1 = value;
         CSR_MAGIC_SECOND: cfg_magic2 = value;
         CSR_VERSION:      cfg_version = value;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [7:0] m1, input logic [7:0] m2, input logic [7:0] v);
      drain_and_settle();
      csr_write(CSR_MAGIC_FIRST, m1);
      csr_write(CSR_MAGIC_SECOND, m2);
      csr_write(CSR_VERSION, v);
   endtask

   // build a packet, optionally damage it, stuff it and push it with its delimiter
   task automatic send_packet(input int plen, input pkt_fault_type fault);
      logic [7:0] pkt[$];
      logic [7:0] enc[$];
      logic [15:0] crc;
      logic [7:0] b;
      int code, code_pos, pos;
      pkt.push_back(cfg_magic1);
      pkt.push_back(cfg_magic2);
      pkt.push_back(cfg_version);
      repeat (4) pkt.push_back(8'($urandom));
      pkt.push_back(plen[7:0]);
      pkt.push_back(8'(plen >> 8));
      for (int i = 0; i < plen; i++)
         pkt.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
      crc = CRC_INIT;
      foreach (pkt[i]) crc = crc16_update(crc, pkt[i]);
      pkt.push_back(crc[7:0]);
      pkt.push_back(crc[15:8]);
      case (fault)
         PKT_BAD_MAGIC:     pkt[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
         PKT_BAD_VERSION:   pkt[2] ^= 8'(1 << $urandom_range(0, 7));
         PKT_BAD_CRC:       pkt[$urandom_range(3, pkt.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
         PKT_BAD_LEN_FIELD: pkt[7] = pkt[7] + 8'($urandom_range(1, 3));
         PKT_TRUNCATED:     repeat ($urandom_range(1, 4)) void'(pkt.pop_back());
         PKT_HUGE_LEN:      pkt[8] = 8'($urandom_range(1, 255));
         default: ;
      endcase
      code = 1;
      code_pos = 0;
      enc.push_back(8'h00);
      foreach (pkt[i]) begin
         if (pkt[i] == 8'h00) begin
            enc[code_pos] = 8'(code);
            code_pos = enc.size();
            enc.push_back(8'h00);
            code = 1;
         end else begin
            enc.push_back(pkt[i]);
            code++;
            if (code == 255) begin
               enc[code_pos] = 8'(code);
               code_pos = enc.size();
               enc.push_back(8'h00);
               code = 1;
            end
         end
      end
      enc[code_pos] = 8'(code);
      if (fault == PKT_CORRUPT_CODE) begin
         pos = $urandom_range(0, enc.size() - 1);
         b = 8'($urandom_range(1, 255));
         enc[pos] = b;
      end
      foreach (enc[i]) send_request(push_req(enc[i]));
      send_request(push_req(8'h00));
   endtask

   task automatic random_traffic(input int until_items);
      int pick, plen;
      while (requests_sent < until_items) begin
         pick = $urandom_range(0, 99);
         plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                              : $urandom_range(0, 16);
         if (pick < 55) send_packet(plen, PKT_GOOD);
         else if (pick < 75) send_packet(plen, pkt_fault_type'($urandom_range(1, 7)));
         else if (pick < 87) begin
            if (good_plen > 0 && $urandom_range(0, 1) == 0)
               send_request(read_req(8'($urandom_range(0, good_plen - 1))));
            else
               send_request(read_req(8'($urandom)));
         end else begin
            // noise, with a delimiter now and then
            repeat ($urandom_range(1, 12))
               send_request(push_req(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom)));
         end
      end
   endtask

   // result side: check accepted responses and drive stall in bursts
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response kind %0d", rsp_payload.kind));
         end else begin
            want = expected_results.pop_front();
            check_field("kind", rsp_payload.kind, want.kind);
            check_field("status", rsp_payload.status, want.status);
            check_field("message_type", rsp_payload.message_type, want.message_type);
            check_field("message_flags", rsp_payload.message_flags, want.message_flags);
            check_field("sequence_number", rsp_payload.sequence_number, want.sequence_number);
            check_field("payload_length", rsp_payload.payload_length, want.payload_length);
            check_field("read_byte", rsp_payload.read_byte, want.read_byte);
            if (want.kind == KIND_GOOD) good_seen++;
            if (want.kind == KIND_ERR) err_seen++;
         end
      end
      if (reset) rsp_stall <= 1'b0;
      else if (long_hold) rsp_stall <= 1'b1;
      else if (quiet) rsp_stall <= 1'b0;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else rsp_stall <= 1'b0;
   end

   // long receiver hold-off while requests keep coming
   initial begin
      wait (requests_sent >= 300);
      @(posedge clock);
      long_hold = 1'b1;
      repeat (400) @(posedge clock);
      long_hold = 1'b0;
   end

   stim_row_type directed[$];

   initial begin
      frame_fill = 0;
      frame_ovf = 1'b0;
      good_plen = 0;
      cfg_magic1 = 8'h00;
      cfg_magic2 = 8'h00;
      cfg_version = 8'h00;

      directed.push_back('{read_req(8'h00), 1, 1, read_rsp(8'h00)});
      directed.push_back('{read_req(8'hFF), 1, 1, read_rsp(8'h00)});
      directed.push_back('{push_req(8'h00), 1, 0, '0});
      directed.push_back('{push_req(8'h01), 1, 0, '0});
      directed.push_back('{push_req(8'h00), 1, 1, err_rsp(ST_BAD_LENGTH)});
      directed.push_back('{push_req(8'h05), 1, 0, '0});
      directed.push_back('{push_req(8'h00), 1, 1, err_rsp(ST_MALFORMED)});
      directed.push_back('{push_req(8'hFF), 1, 0, '0});
      directed.push_back('{push_req(8'h00), 1, 1, err_rsp(ST_MALFORMED)});
      directed.push_back('{push_req(8'h03), 1, 0, '0});
      directed.push_back('{push_req(8'h11), 1, 0, '0});
      directed.push_back('{push_req(8'hEE), 1, 0, '0});
      directed.push_back('{push_req(8'h00), 1, 1, err_rsp(ST_BAD_LENGTH)});
      directed.push_back('{push_req(8'h00), 1, 0, '0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_request(directed[i].req, directed[i].typed, directed[i].t_has, directed[i].t_rsp);
      send_packet(0, PKT_GOOD);
      send_packet(MAX_PAYLOAD, PKT_GOOD);
      send_request(read_req(8'h00));
      send_request(read_req(8'hFF));
      for (int f = 1; f <= 7; f++) send_packet(4, pkt_fault_type'(f));

      load_settings(8'hFF, 8'hFF, 8'hFF);
      random_traffic(450);

      load_settings(8'($urandom), 8'($urandom), 8'($urandom));
      // fill the frame store to capacity, overflow it, then close the frame
      repeat (FRAME_CAPACITY + $urandom_range(1, 6))
         send_request(push_req(8'($urandom_range(1, 255))));
      send_request(push_req(8'h00));
      random_traffic(1100);

      load_settings(8'hA5, 8'h5A, 8'h01);
      random_traffic(ITEM_TARGET);

      drain_and_settle();
      $display("Ran %0d requests over four register settings, frame overflow included.",
               requests_sent);
      $display("Checked %0d responses: %0d good packets, %0d errors, rest reads.",
               results_seen, good_seen, err_seen);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
